FILE: rtl/vn2d_pkg.sv
// Shared types and constants for the 2D fractal value noise pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package vn2d_pkg;

   localparam int FracBits          = 16;
   localparam int OneFx             = 1 << FracBits;
   localparam int MaxOctavesDefault = 8;

   localparam int CoordW  = 32;
   localparam int FreqW   = 32;
   localparam int PersW   = 17;
   localparam int AmpW    = 24;
   localparam int CountW  = 4;
   localparam int SeedW   = 31;
   localparam int OutW    = 32;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 32;

   localparam int HashW    = 32;
   localparam int LatW     = FracBits + 2;
   localparam int SmoothW  = LatW + 4;
   localparam int FacW     = FracBits + 1;
   localparam int ProdW    = SmoothW + FacW + 1;
   localparam int ContribW = FracBits + 2;
   localparam int WeightShift = 20;

   localparam int HashLatency = 3;
   localparam int LaneLatency = 13;
   localparam int TopLatency  = LaneLatency + 3;

   localparam logic [HashW-1:0] HashMulA  = 32'd57;
   localparam int               HashShift = 13;
   localparam logic [HashW-1:0] HashMulB  = 32'd15731;
   localparam logic [HashW-1:0] HashAddB  = 32'd789221;
   localparam logic [HashW-1:0] HashAddC  = 32'd1376312589;

   typedef enum logic [CsrIdxW-1:0] {
      CsrFrequency   = 3'd0,
      CsrPersistence = 3'd1,
      CsrAmplitude   = 3'd2,
      CsrOctaveCount = 3'd3,
      CsrSeedOffset  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FreqW-1:0] frequency;
      logic [SeedW-1:0] seed_offset;
   } lane_cfg_type;

endpackage

`default_nettype wire

FILE: rtl/vn2d_hash.sv
// Three-stage lattice hash: integer hash of one mixed lattice index to a value.
// Depends on vn2d_pkg.
`default_nettype none

module vn2d_hash (
   input  logic                               clock,
   input  logic [vn2d_pkg::HashW-1:0]         hash_in,
   output logic signed [vn2d_pkg::LatW-1:0]   lattice_value
);
   import vn2d_pkg::*;

   logic [HashW-1:0]        n1_ff, nn_ff, n2_ff, t_ff;
   logic [HashW-1:0]        nn_in, t_in, h;
   logic signed [LatW-1:0]  lat_ff, lat_in;

   assign nn_in = hash_in * hash_in;
   assign t_in  = nn_ff * HashMulB + HashAddB;
   assign h     = n2_ff * t_ff + HashAddC;
   assign lat_in = $signed(LatW'(OneFx)) - $signed({1'b0, h[30:30-FracBits]});

   always_ff @(posedge clock) begin
      n1_ff  <= hash_in;
      nn_ff  <= nn_in;
      n2_ff  <= n1_ff;
      t_ff   <= t_in;
      lat_ff <= lat_in;
   end

   assign lattice_value = lat_ff;

endmodule

`default_nettype wire

FILE: rtl/vn2d_octave.sv
// One octave lane: scale, 4x4 lattice hash, 3x3 smoothing, smoothstep blend, weight.
// Depends on vn2d_pkg and vn2d_hash.
`default_nettype none

module vn2d_octave #(
   parameter int OCTAVE = 0
) (
   input  logic                                  clock,
   input  logic [vn2d_pkg::CoordW-1:0]           coord_x,
   input  logic [vn2d_pkg::CoordW-1:0]           coord_y,
   input  vn2d_pkg::lane_cfg_type                cfg,
   input  logic [vn2d_pkg::PersW-1:0]            weight,
   output logic signed [vn2d_pkg::ContribW-1:0]  contrib
);
   import vn2d_pkg::*;

   // scale
   logic signed [2*CoordW:0]  prod_x, prod_y;
   logic [2*CoordW-1:0]       px_ff, py_ff, shx, shy;
   logic [HashW-1:0]          u_ff, v_ff, u_in, v_in;
   logic [FracBits-1:0]       au_ff, av_ff, au3_ff, av3_ff;
   logic [2*FracBits-1:0]     sqr_u, sqr_v;
   logic [FracBits-1:0]       a2u_ff, a2v_ff;
   logic [FracBits+2-1:0]     cub_u, cub_v;
   logic [2*FracBits+2-1:0]   f2u_full, f2v_full;
   logic [FacW-1:0]           f2u_ff [4];
   logic [FacW-1:0]           f2v_ff [6];
   logic [FacW-1:0]           f1u, f1v;

   // hash
   logic [HashW-1:0]          v57;
   logic [HashW-1:0]          n_in [16];
   logic [HashW-1:0]          n_ff [16];
   logic signed [LatW-1:0]    lat [16];

   // smoothing and blend
   logic signed [SmoothW-1:0] sm_in [4];
   logic signed [SmoothW-1:0] sm_ff [4];
   logic signed [ProdW-1:0]   p_ff [4];
   logic signed [ProdW:0]     bsum1, bsum2, fsum;
   logic signed [SmoothW-1:0] v1_ff, v2_ff, fin_ff;
   logic signed [ProdW-1:0]   q1_ff, q2_ff, wp_ff;
   logic signed [ContribW-1:0] contrib_ff;

   assign prod_x = $signed(coord_x) * $signed({1'b0, cfg.frequency});
   assign prod_y = $signed(coord_y) * $signed({1'b0, cfg.frequency});

   assign shx  = px_ff << OCTAVE;
   assign shy  = py_ff << OCTAVE;
   assign u_in = shy[2*CoordW-1:CoordW] + {1'b0, cfg.seed_offset};
   assign v_in = shx[2*CoordW-1:CoordW] + {1'b0, cfg.seed_offset};

   assign sqr_u = au_ff * au_ff;
   assign sqr_v = av_ff * av_ff;
   assign cub_u = (FracBits+2)'(3 * OneFx) - {1'b0, au3_ff, 1'b0};
   assign cub_v = (FracBits+2)'(3 * OneFx) - {1'b0, av3_ff, 1'b0};
   assign f2u_full = a2u_ff * cub_u;
   assign f2v_full = a2v_ff * cub_v;
   assign f1u = FacW'(OneFx) - f2u_ff[3];
   assign f1v = FacW'(OneFx) - f2v_ff[5];

   assign v57 = v_ff * HashMulA;

   always_comb begin
      logic [HashW-1:0] n;
      for (int gu = 0; gu < 4; gu++) begin
         for (int gv = 0; gv < 4; gv++) begin
            n = u_ff + v57 + HashW'((gu - 1) + 57 * (gv - 1));
            n_in[gu*4+gv] = n ^ (n << HashShift);
         end
      end
   end

   for (genvar g = 0; g < 16; g++) begin : g_hash
      vn2d_hash u_hash (
         .clock         (clock),
         .hash_in       (n_ff[g]),
         .lattice_value (lat[g])
      );
   end

   always_comb begin
      int gu, gv;
      for (int c = 0; c < 4; c++) begin
         gu = c / 2 + 1;
         gv = c % 2 + 1;
         sm_in[c] = SmoothW'(lat[(gu-1)*4+gv-1]) + SmoothW'(lat[(gu+1)*4+gv-1])
                  + SmoothW'(lat[(gu-1)*4+gv+1]) + SmoothW'(lat[(gu+1)*4+gv+1])
                  + ((SmoothW'(lat[(gu-1)*4+gv]) + SmoothW'(lat[(gu+1)*4+gv])
                  + SmoothW'(lat[gu*4+gv-1]) + SmoothW'(lat[gu*4+gv+1])) <<< 1)
                  + (SmoothW'(lat[gu*4+gv]) <<< 2);
      end
   end

   assign bsum1 = (ProdW+1)'(p_ff[0]) + (ProdW+1)'(p_ff[1]);
   assign bsum2 = (ProdW+1)'(p_ff[2]) + (ProdW+1)'(p_ff[3]);
   assign fsum  = (ProdW+1)'(q1_ff) + (ProdW+1)'(q2_ff);

   always_ff @(posedge clock) begin
      px_ff  <= prod_x[2*CoordW-1:0];
      py_ff  <= prod_y[2*CoordW-1:0];
      u_ff   <= u_in;
      v_ff   <= v_in;
      au_ff  <= shy[CoordW-1:CoordW-FracBits];
      av_ff  <= shx[CoordW-1:CoordW-FracBits];
      au3_ff <= au_ff;
      av3_ff <= av_ff;
      a2u_ff <= sqr_u[2*FracBits-1:FracBits];
      a2v_ff <= sqr_v[2*FracBits-1:FracBits];
      n_ff   <= n_in;
      f2u_ff[0] <= f2u_full[FracBits+FacW-1:FracBits];
      f2v_ff[0] <= f2v_full[FracBits+FacW-1:FracBits];
      for (int k = 1; k < 4; k++) f2u_ff[k] <= f2u_ff[k-1];
      for (int k = 1; k < 6; k++) f2v_ff[k] <= f2v_ff[k-1];
      sm_ff  <= sm_in;
      p_ff[0] <= sm_ff[0] * $signed({1'b0, f1u});
      p_ff[1] <= sm_ff[2] * $signed({1'b0, f2u_ff[3]});
      p_ff[2] <= sm_ff[1] * $signed({1'b0, f1u});
      p_ff[3] <= sm_ff[3] * $signed({1'b0, f2u_ff[3]});
      v1_ff  <= bsum1[FracBits+SmoothW-1:FracBits];
      v2_ff  <= bsum2[FracBits+SmoothW-1:FracBits];
      q1_ff  <= v1_ff * $signed({1'b0, f1v});
      q2_ff  <= v2_ff * $signed({1'b0, f2v_ff[5]});
      fin_ff <= fsum[FracBits+SmoothW-1:FracBits];
      wp_ff  <= fin_ff * $signed({1'b0, weight});
      contrib_ff <= wp_ff[WeightShift+ContribW-1:WeightShift];
   end

   assign contrib = contrib_ff;

endmodule

`default_nettype wire

FILE: rtl/value_noise_2d_octaves.sv
// Top level of the 2D fractal value noise block: config registers, octave lanes,
// octave sum, gain and saturation. Depends on vn2d_pkg and vn2d_octave.
//
// Usage:
//   Input: drive req_coord_x/req_coord_y (signed Q16.16) and raise start; a
//   transfer happens at each rising edge with start high and busy low. busy
//   stays low, so one point is taken every clock.
//   Output: rsp_strobe is high for one cycle with rsp_noise_value; results
//   come out in input order. The receiver cannot stall, so the pipeline
//   never holds.
//   Throughput: one item per clock. Each point passes the 13-stage octave
//   lanes (scale multiply, three-stage hash, smoothing, two blend
//   multiplies, weight multiply), then octave sum, gain multiply and output.
//   Configuration: csr_valid/csr_ready/csr_index/csr_wdata, ready always high.
//   Write only while no point is in flight; the persistence weight chain is
//   registered, each octave weight taken from the one before it.
//   Reset: synchronous, clears the valid pipeline and all config registers.
`default_nettype none

module value_noise_2d_octaves #(
   parameter int MAX_OCTAVES = vn2d_pkg::MaxOctavesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [vn2d_pkg::CoordW-1:0]     req_coord_x,
   input  logic [vn2d_pkg::CoordW-1:0]     req_coord_y,
   output logic                            rsp_strobe,
   output logic [vn2d_pkg::OutW-1:0]       rsp_noise_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vn2d_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [vn2d_pkg::CsrDatW-1:0]    csr_wdata
);
   import vn2d_pkg::*;

   localparam int SumW     = ContribW + 1 + $clog2(MAX_OCTAVES + 1);
   localparam int AmpProdW = AmpW + SumW;
   localparam int ResW     = AmpProdW - FracBits;

   logic [FreqW-1:0]           frequency_ff;
   logic [PersW-1:0]           persistence_ff;
   logic [AmpW-1:0]            amplitude_ff;
   logic [CountW-1:0]          octave_count_ff;
   logic [SeedW-1:0]           seed_offset_ff;
   logic                       csr_xfer;

   logic [PersW-1:0]           pers_clamped;
   logic [PersW-1:0]           weight_ff [MAX_OCTAVES];
   logic [2*PersW-1:0]         weight_prod [MAX_OCTAVES];

   lane_cfg_type               lane_cfg;
   logic signed [ContribW-1:0] contrib [MAX_OCTAVES];
   logic signed [SumW-1:0]     sum_ff, sum_in;
   logic signed [AmpProdW-1:0] amp_ff;
   logic signed [ResW-1:0]     res;
   logic [OutW-1:0]            out_ff, out_in;
   logic [TopLatency-1:0]      valid_ff, valid_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frequency_ff    <= '0;
         persistence_ff  <= '0;
         amplitude_ff    <= '0;
         octave_count_ff <= '0;
         seed_offset_ff  <= '0;
      end else if (csr_xfer) begin
         case (csr_index_type'(csr_index))
            CsrFrequency:   frequency_ff    <= csr_wdata[FreqW-1:0];
            CsrPersistence: persistence_ff  <= csr_wdata[PersW-1:0];
            CsrAmplitude:   amplitude_ff    <= csr_wdata[AmpW-1:0];
            CsrOctaveCount: octave_count_ff <= csr_wdata[CountW-1:0];
            CsrSeedOffset:  seed_offset_ff  <= csr_wdata[SeedW-1:0];
            default: ;
         endcase
      end
   end

   assign pers_clamped = (persistence_ff > PersW'(OneFx)) ? PersW'(OneFx) : persistence_ff;

   assign weight_prod[0] = '0;
   for (genvar k = 1; k < MAX_OCTAVES; k++) begin : g_wprod
      assign weight_prod[k] = weight_ff[k-1] * pers_clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[0] <= PersW'(OneFx);
         for (int k = 1; k < MAX_OCTAVES; k++) weight_ff[k] <= '0;
      end else begin
         weight_ff[0] <= PersW'(OneFx);
         for (int k = 1; k < MAX_OCTAVES; k++)
            weight_ff[k] <= weight_prod[k][16+PersW-1:16];
      end
   end

   assign lane_cfg.frequency   = frequency_ff;
   assign lane_cfg.seed_offset = seed_offset_ff;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
      vn2d_octave #(.OCTAVE(k)) u_octave (
         .clock   (clock),
         .coord_x (req_coord_x),
         .coord_y (req_coord_y),
         .cfg     (lane_cfg),
         .weight  (weight_ff[k]),
         .contrib (contrib[k])
      );
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         if (octave_count_ff > CountW'(k)) sum_in = sum_in + SumW'(contrib[k]);
      end
   end

   assign res = amp_ff[AmpProdW-1:FracBits];

   if (ResW > OutW) begin : g_sat
      always_comb begin
         if (res > $signed(ResW'({1'b0, {(OutW-1){1'b1}}})))
            out_in = {1'b0, {(OutW-1){1'b1}}};
         else if (res < -$signed(ResW'({1'b1, {(OutW-1){1'b0}}})))
            out_in = {1'b1, {(OutW-1){1'b0}}};
         else
            out_in = res[OutW-1:0];
      end
   end else begin : g_nosat
      assign out_in = OutW'(res);
   end

   assign valid_in = {valid_ff[TopLatency-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      amp_ff <= $signed(amplitude_ff) * sum_ff;
      out_ff <= out_in;
   end

   assign rsp_strobe      = valid_ff[TopLatency-1];
   assign rsp_noise_value = out_ff;

   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, TopLatency))
      else $error("result strobe without a matching input transfer");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      ($signed(sum_ff) <= $signed(SumW'(MAX_OCTAVES * OneFx)))
      && ($signed(sum_ff) >= -$signed(SumW'(MAX_OCTAVES * OneFx))))
      else $error("octave sum out of range");

   for (genvar k = 1; k < MAX_OCTAVES; k++) begin : g_wchk
      a_weight_falls: assert property (@(posedge clock) disable iff (reset)
         weight_ff[k] <= $past(weight_ff[k-1]))
         else $error("octave weight grew along the chain");
   end

endmodule

`default_nettype wire

FILE: test/value_noise_2d_octaves_test.sv
// Testbench for value_noise_2d_octaves: random and directed points under several
// register settings, checked against an in-bench fractal value noise predictor.
// Depends on vn2d_pkg and the value_noise_2d_octaves RTL.
`default_nettype none

module value_noise_2d_octaves_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vn2d_pkg::*;

   class noise_scoreboard;
      bit [31:0] frequency;
      bit [16:0] persistence;
      bit [23:0] amplitude;
      bit [3:0]  octave_count;
      bit [30:0] seed_offset;
      logic [31:0] pending_noise[$];
      int mismatches;

      function longint floor_shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint lattice_value(bit [31:0] u, bit [31:0] v);
         bit [31:0] n;
         bit [31:0] h;
         n = u + v * 32'd57;
         n = (n << 13) ^ n;
         h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
         return 65536 - longint'(h >> 14);
      endfunction

      function longint smoothed(bit [31:0] u, bit [31:0] v);
         longint c;
         longint e;
         c = lattice_value(u - 1, v - 1) + lattice_value(u + 1, v - 1)
           + lattice_value(u - 1, v + 1) + lattice_value(u + 1, v + 1);
         e = lattice_value(u - 1, v) + lattice_value(u + 1, v)
           + lattice_value(u, v - 1) + lattice_value(u, v + 1);
         return c + 2 * e + 4 * lattice_value(u, v);
      endfunction

      function longint mix(longint lo, longint hi, longint a);
         longint a2;
         longint f2;
         a2 = (a * a) >>> 16;
         f2 = (a2 * (3 * 65536 - 2 * a)) >>> 16;
         return floor_shr(lo * (65536 - f2) + hi * f2, 16);
      endfunction

      function void split(longint c, bit [63:0] f, output bit [31:0] ip,
                          output longint fp);
         bit [63:0] q;
         q = (64'(c) * f) >> 16;
         q = q + (64'(seed_offset) << 16);
         ip = q[47:16];
         fp = longint'(q[15:0]);
      endfunction

      function logic [31:0] noise_of(logic [31:0] x, logic [31:0] y);
         longint sum;
         longint weight;
         longint p;
         longint au;
         longint av;
         longint v1;
         longint v2;
         longint fin;
         longint res;
         bit [31:0] u;
         bit [31:0] v;
         int n;
         sum = 0;
         weight = 65536;
         n = octave_count > 8 ? 8 : octave_count;
         p = persistence > 65536 ? 65536 : persistence;
         for (int i = 0; i < n; i++) begin
            split(longint'($signed(y)), 64'(frequency) << i, u, au);
            split(longint'($signed(x)), 64'(frequency) << i, v, av);
            v1 = mix(smoothed(u, v), smoothed(u + 1, v), au);
            v2 = mix(smoothed(u, v + 1), smoothed(u + 1, v + 1), au);
            fin = mix(v1, v2, av);
            sum += floor_shr(fin * weight, 20);
            weight = (weight * p) >>> 16;
         end
         res = floor_shr(longint'($signed(amplitude)) * sum, 16);
         if (res > 64'sd2147483647) res = 64'sd2147483647;
         if (res < -64'sd2147483648) res = -64'sd2147483648;
         return res[31:0];
      endfunction

      function void note_point(logic [31:0] x, logic [31:0] y);
         pending_noise.push_back(noise_of(x, y));
      endfunction

      function void check_noise(logic [31:0] got);
         logic [31:0] want;
         if (pending_noise.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending_noise.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("noise_value mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [31:0] req_coord_x = 0;
   logic [31:0] req_coord_y = 0;
   logic rsp_strobe;
   logic [31:0] rsp_noise_value;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = CsrFrequency;
   logic [31:0] csr_wdata = 0;

   noise_scoreboard board = new();

   value_noise_2d_octaves uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) board.note_point(req_coord_x, req_coord_y);
      if (!reset && rsp_strobe) board.check_noise(rsp_noise_value);
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrFrequency:   board.frequency = data;
         CsrPersistence: board.persistence = data[16:0];
         CsrAmplitude:   board.amplitude = data[23:0];
         CsrOctaveCount: board.octave_count = data[3:0];
         default:        board.seed_offset = data[30:0];
      endcase
   endtask

   task automatic configure(logic [31:0] f, logic [31:0] p, logic [31:0] a,
                            logic [31:0] n, logic [31:0] s);
      write_csr(CsrFrequency, f);
      write_csr(CsrPersistence, p);
      write_csr(CsrAmplitude, a);
      write_csr(CsrOctaveCount, n);
      write_csr(CsrSeedOffset, s);
      csr_valid <= 0;
   endtask

   task automatic send_point(logic [31:0] x, logic [31:0] y, bit gaps);
      int g;
      g = 0;
      if (gaps) g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                  : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (g > 0) begin
         start <= 0;
         repeat (g) @(posedge clock);
      end
      start <= 1;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      start <= 0;
      while (board.pending_noise.size() != 0) @(posedge clock);
      repeat (TopLatency + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 8) << 14;
         1: return 32'h8000_0000 | $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] edges[6];
      edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000, 32'hffff8000};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_point(32'h0001_8000, 32'h0002_4000, 0);
      drain();
      configure(32'h0001_0000, 32'h8000, 32'h01_0000, 4, 0);
      foreach (edges[i]) send_point(edges[i], edges[5 - i], 0);
      send_point(32'h0003_0000, 32'hfffd_0000, 0);
      drain();
      configure(32'hffffffff, 32'h1ffff, 32'h7fffff, 15, 32'h7fffffff);
      foreach (edges[i]) send_point(edges[i], edges[i], 0);
      drain();
      configure(32'h0004_0000, 32'h10000, 32'h800000, 8, 2);
      foreach (edges[i]) send_point(edges[i], $urandom, 0);
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         configure($urandom, $urandom_range(0, 70000), $urandom, $urandom_range(0, 15),
                   $urandom & 32'h7fffffff);
         for (int k = 0; k < 50; k++) send_point(rand_coord(), rand_coord(), phase % 3 != 0);
         drain();
      end
      if (board.mismatches == 0) $display("PASS value_noise_2d_octaves");
      else $display("FAIL value_noise_2d_octaves");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL value_noise_2d_octaves");
      $finish;
   end
endmodule

`default_nettype wire
